### design/ttp_pkg.sv
// ----------------------------------------------------------------------------
// ttp_pkg
// Shared constants, types and helpers for the table thinning pass.
// ----------------------------------------------------------------------------
`default_nettype none

package ttp_pkg;

  localparam int MaxWidth    = 1024;
  localparam int HeightLimit = 1024;
  localparam int MinSize     = 3;

  localparam int PosW    = $clog2(MaxWidth);
  localparam int WidW    = $clog2(MaxWidth + 1);
  localparam int SumW    = WidW + 1;
  localparam int RowPosW = $clog2(HeightLimit);
  localparam int HgtW    = $clog2(HeightLimit + 1);
  localparam int HSumW   = HgtW + 1;

  localparam int CfgSizeW = 11;
  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 3;
  localparam int PixelW   = 8;
  localparam int CountW   = 21;
  localparam int RuleRegs = 4;
  localparam int CodeW    = 8;
  localparam int RuleBits = RuleRegs * CfgDataW;

  localparam logic [CfgSizeW-1:0] ResetRowWidth    = CfgSizeW'(640);
  localparam logic [CfgSizeW-1:0] ResetFrameHeight = CfgSizeW'(480);
  localparam logic [CountW-1:0]   CountMax         = {CountW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    RegRowWidth    = 3'd0,
    RegFrameHeight = 3'd1,
    RegRules0      = 3'd2,
    RegRules1      = 3'd3,
    RegRules2      = 3'd4,
    RegRules3      = 3'd5
  } ttp_reg_t;

  // item in the line store read stage
  typedef struct packed {
    logic            decide;
    logic            frame_start;
    logic            interior;
    logic            frame_end;
    logic            cur;
    logic            prev1;
    logic            prev2;
    logic            mid_we;
    logic [PosW-1:0] addr;
  } ttp_stage_t;

  function automatic logic [WidW-1:0] clamp_width(input logic [CfgSizeW-1:0] v);
    if (int'(v) < MinSize) return WidW'(MinSize);
    if (int'(v) > MaxWidth) return WidW'(MaxWidth);
    return WidW'(v);
  endfunction

  function automatic logic [HgtW-1:0] clamp_height(input logic [CfgSizeW-1:0] v);
    if (int'(v) < MinSize) return HgtW'(MinSize);
    if (int'(v) > HeightLimit) return HgtW'(HeightLimit);
    return HgtW'(v);
  endfunction

endpackage

`default_nettype wire

### design/table_thinning_pass.sv
// ----------------------------------------------------------------------------
// table_thinning_pass
// One in-place raster thinning pass over a binary image, 3x3 rule table.
// ----------------------------------------------------------------------------
// Takes one pixel item per clock while in_stall is low and gives at most
// one result per clock. Results lag the input by row_width+1 items: after
// the last pixel of a frame, send row_width+1 flush items to drain it. The
// previous and current rows live in two 1-bit line memories (one write, two
// reads, registered); each item reads columns c and c+1 from both and writes
// column c back as it leaves the read stage, so the read stage sets the rate
// of one item per clock unless out_stall holds it. row_width and frame_height
// are latched at a frame's first pixel. The line memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module table_thinning_pass (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [ttp_pkg::PixelW-1:0]     pixel,
  input  wire logic                           flush,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_pixel,
  output logic                                frame_end,
  output logic [ttp_pkg::CountW-1:0]          removed_count,
  input  wire logic                           cfg_write,
  input  wire logic [ttp_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [ttp_pkg::CfgDataW-1:0]   cfg_data
);
  import ttp_pkg::*;

  // configuration
  logic [CfgSizeW-1:0] row_width;
  logic [CfgSizeW-1:0] frame_height;
  logic [CfgDataW-1:0] remove_rules [RuleRegs];
  logic [RuleBits-1:0] rules;

  // input side state
  logic [WidW-1:0]    frame_w, frame_w_next;
  logic [HgtW-1:0]    frame_h, frame_h_next;
  logic [PosW-1:0]    column_count, column_count_next;
  logic [HgtW-1:0]    row_count, row_count_next;
  logic [PosW-1:0]    out_col, out_col_next;
  logic [RowPosW-1:0] out_row, out_row_next;
  logic               inputs_done, inputs_done_next;
  logic [1:0]         window_bits, window_bits_next;

  // read stage
  logic       b_valid, b_valid_next;
  ttp_stage_t b, b_next;
  logic       mid_c, mid_e, up_c, up_e;
  logic       u_w, m_w;
  logic [CountW-1:0] cleared_total;

  // line memories
  logic mid_mem [MaxWidth];
  logic up_mem  [MaxWidth];

  logic              accept, valid_in, drain, active, first;
  logic [WidW-1:0]   fw;
  logic [HgtW-1:0]   fh;
  logic [PosW-1:0]   oc;
  logic [RowPosW-1:0] orow;
  logic              cur, decide, last_col, frame_end_a, interior;
  logic [WidW-1:0]   col_inc;
  logic [HgtW-1:0]   row_inc;
  logic [PosW-1:0]   rd_addr, e_addr;

  logic              out_free, b_adv;
  logic [CodeW-1:0]  code;
  logic              clr, v;
  logic [CountW-1:0] base, total;

  assign rules = {remove_rules[3], remove_rules[2], remove_rules[1], remove_rules[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= ResetRowWidth;
      frame_height <= ResetFrameHeight;
      for (int i = 0; i < RuleRegs; i++) begin
        remove_rules[i] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegRowWidth:    row_width       <= cfg_data[CfgSizeW-1:0];
        RegFrameHeight: frame_height    <= cfg_data[CfgSizeW-1:0];
        RegRules0:      remove_rules[0] <= cfg_data;
        RegRules1:      remove_rules[1] <= cfg_data;
        RegRules2:      remove_rules[2] <= cfg_data;
        RegRules3:      remove_rules[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign b_adv    = b_valid && (!b.decide || out_free);
  assign in_stall = b_valid && !b_adv;
  assign accept   = in_valid && !in_stall;

  // input side: positions, window, read addresses
  always_comb begin
    valid_in = !flush && !inputs_done;
    drain    = inputs_done;
    active   = valid_in || drain;
    first    = valid_in && (row_count == '0) && (column_count == '0);
    fw       = first ? clamp_width(row_width) : frame_w;
    fh       = first ? clamp_height(frame_height) : frame_h;
    oc       = first ? '0 : out_col;
    orow     = first ? '0 : out_row;
    cur      = valid_in && (pixel != '0);
    decide   = drain || (row_count > HgtW'(1)) ||
               ((row_count == HgtW'(1)) && (column_count != '0));
    last_col    = (WidW'(oc) + WidW'(1)) == fw;
    frame_end_a = ((HgtW'(orow) + HgtW'(1)) >= fh) && last_col;
    interior    = (orow != '0) && ((HSumW'(orow) + HSumW'(2)) <= HSumW'(fh)) &&
                  (oc != '0) && ((SumW'(oc) + SumW'(2)) <= SumW'(fw));
    col_inc  = WidW'(column_count) + WidW'(1);
    row_inc  = row_count + HgtW'(1);
    rd_addr  = oc;
    e_addr   = last_col ? oc : PosW'(oc + PosW'(1));

    frame_w_next      = frame_w;
    frame_h_next      = frame_h;
    column_count_next = column_count;
    row_count_next    = row_count;
    out_col_next      = out_col;
    out_row_next      = out_row;
    inputs_done_next  = inputs_done;
    window_bits_next  = window_bits;

    b_next.decide      = decide;
    b_next.frame_start = first;
    b_next.interior    = interior;
    b_next.frame_end   = frame_end_a;
    b_next.cur         = cur;
    b_next.prev1       = window_bits[0];
    b_next.prev2       = window_bits[1];
    b_next.mid_we      = valid_in && (row_count == '0);
    b_next.addr        = decide ? oc : column_count;

    if (accept && active) begin
      frame_w_next     = fw;
      frame_h_next     = fh;
      out_col_next     = oc;
      out_row_next     = orow;
      window_bits_next = {window_bits[0], cur};
      if (valid_in) begin
        if (col_inc >= fw) begin
          column_count_next = '0;
          row_count_next    = row_inc;
          if (row_inc >= fh) begin
            inputs_done_next = 1'b1;
          end
        end else begin
          column_count_next = PosW'(col_inc);
        end
      end
      if (decide) begin
        if (frame_end_a) begin
          out_col_next      = '0;
          out_row_next      = '0;
          column_count_next = '0;
          row_count_next    = '0;
          inputs_done_next  = 1'b0;
        end else if (last_col) begin
          out_col_next = '0;
          out_row_next = orow + RowPosW'(1);
        end else begin
          out_col_next = PosW'(oc + PosW'(1));
        end
      end
    end

    if (accept && active) begin
      b_valid_next = 1'b1;
    end else if (b_adv) begin
      b_valid_next = 1'b0;
    end else begin
      b_valid_next = b_valid;
    end
  end

  // read stage: neighbor code, rule lookup, write back
  always_comb begin
    code  = {b.cur, b.prev1, b.prev2, m_w, u_w, up_c, up_e, mid_e};
    clr   = b.decide && b.interior && mid_c && rules[code];
    v     = mid_c && !clr;
    base  = b.frame_start ? '0 : cleared_total;
    total = (clr && (base != CountMax)) ? base + CountW'(1) : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w       <= clamp_width(ResetRowWidth);
      frame_h       <= clamp_height(ResetFrameHeight);
      column_count  <= '0;
      row_count     <= '0;
      out_col       <= '0;
      out_row       <= '0;
      inputs_done   <= 1'b0;
      window_bits   <= '0;
      b_valid       <= 1'b0;
      out_valid     <= 1'b0;
      cleared_total <= '0;
    end else begin
      frame_w      <= frame_w_next;
      frame_h      <= frame_h_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      out_col      <= out_col_next;
      out_row      <= out_row_next;
      inputs_done  <= inputs_done_next;
      window_bits  <= window_bits_next;
      b_valid      <= b_valid_next;
      if (b_adv) begin
        cleared_total <= total;
      end
      if (b_adv && b.decide) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active) begin
      b <= b_next;
    end
    if (b_adv && b.decide) begin
      u_w           <= up_c;
      m_w           <= v;
      out_pixel     <= v;
      frame_end     <= b.frame_end;
      removed_count <= b.frame_end ? total : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active) begin
      mid_c <= mid_mem[rd_addr];
      mid_e <= mid_mem[e_addr];
      up_c  <= up_mem[rd_addr];
      up_e  <= up_mem[e_addr];
    end
    if (b_adv) begin
      if (b.decide) begin
        up_mem[b.addr]  <= v;
        mid_mem[b.addr] <= b.prev1;
      end else if (b.mid_we) begin
        mid_mem[b.addr] <= b.cur;
      end
    end
  end

endmodule

`default_nettype wire
